>>> src/aca_pkg.sv
// Shared types and constants for the ADC channel averaging and calibration block.
`timescale 1ns / 1ps
package aca_pkg;

  localparam int NUM_CH     = 4;
  localparam int CH_W       = 2;
  localparam int SMP_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  // divider: dividend covers supply*vref (28 bits), divisor covers 16-bit values
  localparam int DVD_W      = 28;
  localparam int DVS_W      = 16;
  localparam int OUT_DATA_W = 120;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TS_CAL_LOW    = 3'd0,
    REG_TS_CAL_HIGH   = 3'd1,
    REG_VREF_CAL      = 3'd2,
    REG_SUPPLY_MV     = 3'd3,
    REG_CAL_TEMP_LOW  = 3'd4,
    REG_CAL_TEMP_HIGH = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    DIV_TEMP,
    DIV_REF
  } div_op_t;

  typedef struct packed {
    logic            acc_en;
    logic            acc_last;
    logic [CH_W-1:0] acc_ch;
    logic            div_start;
    div_op_t         div_op;
    logic [CH_W-1:0] avg_ch;
    logic            avg_ld;
    logic            mul_ld;
    logic            temp_ld;
    logic            ref_ld;
    logic            out_ld;
  } aca_cmd_t;

  typedef struct packed {
    logic div_done;
  } aca_sts_t;

endpackage

>>> src/aca_div.sv
// Iterative restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module aca_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [aca_pkg::DVD_W-1:0] dividend,
  input  logic [aca_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [aca_pkg::DVD_W-1:0] quotient
);
  import aca_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVD_W-1:0] quo_r;

  logic [DVS_W:0]   rem_sh;
  logic             ge;
  logic [DVS_W-1:0] rem_nxt;
  logic [DVD_W-1:0] quo_nxt;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DVD_W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_nxt = ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
    quo_nxt = {quo_r[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> src/aca_dp.sv
// Datapath: calibration registers, channel accumulators, averages, products and result.
`timescale 1ns / 1ps
module aca_dp #(
  parameter int SUM_W  = 19,
  parameter int ROUNDS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [aca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aca_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [aca_pkg::SMP_W-1:0]      sample,
  input  aca_pkg::aca_cmd_t              cmd,
  output aca_pkg::aca_sts_t              sts,
  output logic [aca_pkg::OUT_DATA_W-1:0] out_data
);
  import aca_pkg::*;

  // floor(sum / ROUNDS) as (sum * RCP_M) >> RCP_K, exact for every SUM_W-bit sum
  localparam int RCP_K  = SUM_W + $clog2(ROUNDS);
  localparam int RCP_W  = SUM_W + 1;
  localparam int PROD_W = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_M =
    RCP_W'(((64'd1 << RCP_K) + 64'(ROUNDS) - 64'd1) / 64'(ROUNDS));

  // calibration registers
  logic [15:0]       ts_low_r;
  logic [15:0]       ts_high_r;
  logic [15:0]       vref_r;
  logic [11:0]       supply_r;
  logic signed [8:0] cal_low_r;
  logic signed [8:0] cal_high_r;

  logic [SUM_W-1:0]  sum_r  [NUM_CH];
  logic [SUM_W-1:0]  snap_r [NUM_CH];
  logic [15:0]       avg_r  [NUM_CH];

  logic [DVD_W-1:0]  p_in_r;
  logic [DVD_W-1:0]  p_bat_r;
  logic [DVD_W-1:0]  p_ref_r;
  logic [25:0]       tmag_r;
  logic [15:0]       span_mag_r;
  logic              tneg_r;
  logic              tfault_r;
  logic [9:0]        temp_r;
  logic [15:0]       ref_r;
  logic              rfault_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  dvs;
  logic              div_done;
  logic [DVD_W-1:0]  quo;

  logic [PROD_W-1:0]  avg_prod;
  logic [31:0]        avg_q;
  logic [15:0]        avg_sat;

  logic signed [9:0]  dt;
  logic signed [16:0] ds;
  logic signed [26:0] dt_x;
  logic signed [26:0] ds_x;
  logic signed [26:0] prod;
  logic signed [16:0] span;
  logic signed [28:0] q_s;
  logic signed [28:0] t_s;
  logic signed [28:0] cal_low_x;
  logic [9:0]         temp_sat;
  logic [15:0]        quo_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_low_r   <= 16'd0;
      ts_high_r  <= 16'hFFFF;
      vref_r     <= 16'd0;
      supply_r   <= 12'd3300;
      cal_low_r  <= 9'sd30;
      cal_high_r <= 9'sd110;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TS_CAL_LOW:    ts_low_r   <= cfg_wdata;
        REG_TS_CAL_HIGH:   ts_high_r  <= cfg_wdata;
        REG_VREF_CAL:      vref_r     <= cfg_wdata;
        REG_SUPPLY_MV:     supply_r   <= cfg_wdata[11:0];
        REG_CAL_TEMP_LOW:  cal_low_r  <= cfg_wdata[8:0];
        REG_CAL_TEMP_HIGH: cal_high_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // accumulate; the closing sample goes straight into the snapshot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) sum_r[i] <= '0;
    end else if (cmd.acc_en) begin
      for (int i = 0; i < NUM_CH; i++) begin
        if (cmd.acc_last) begin
          sum_r[i] <= '0;
        end else if (cmd.acc_ch == CH_W'(i)) begin
          sum_r[i] <= sum_r[i] + SUM_W'(sample);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en && cmd.acc_last) begin
      for (int i = 0; i < NUM_CH; i++) begin
        snap_r[i] <= (cmd.acc_ch == CH_W'(i)) ? sum_r[i] + SUM_W'(sample) : sum_r[i];
      end
    end
  end

  // one channel average per cycle
  always_comb begin
    avg_prod = PROD_W'(snap_r[cmd.avg_ch]) * PROD_W'(RCP_M);
    avg_q    = 32'(avg_prod >> RCP_K);
    avg_sat  = (avg_q > 32'd65535) ? 16'hFFFF : avg_q[15:0];
  end

  always_comb begin
    case (cmd.div_op)
      DIV_TEMP: begin
        dvd = DVD_W'(tmag_r);
        dvs = span_mag_r;
      end
      DIV_REF: begin
        dvd = p_ref_r;
        dvs = avg_r[3];
      end
    endcase
  end

  aca_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  assign sts.div_done = div_done;
  assign quo_sat      = (|quo[DVD_W-1:16]) ? 16'hFFFF : quo[15:0];

  // temperature terms, signed
  always_comb begin
    dt   = {cal_high_r[8], cal_high_r} - {cal_low_r[8], cal_low_r};
    ds   = {1'b0, avg_r[2]} - {1'b0, ts_low_r};
    dt_x = dt;
    ds_x = ds;
    prod = dt_x * ds_x;
    span = {1'b0, ts_high_r} - {1'b0, ts_low_r};
  end

  // signed quotient plus offset, then clamp to the 10-bit field
  always_comb begin
    q_s       = tneg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    cal_low_x = cal_low_r;
    t_s       = q_s + cal_low_x;
    if (t_s > 29'sd511) begin
      temp_sat = 10'h1FF;
    end else if (t_s < -29'sd512) begin
      temp_sat = 10'h200;
    end else begin
      temp_sat = t_s[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.avg_ld) begin
      avg_r[cmd.avg_ch] <= avg_sat;
    end
    if (cmd.mul_ld) begin
      p_in_r     <= DVD_W'(avg_r[0]) * DVD_W'(supply_r);
      p_bat_r    <= DVD_W'(avg_r[1]) * DVD_W'(supply_r);
      p_ref_r    <= DVD_W'(supply_r) * DVD_W'(vref_r);
      tmag_r     <= prod[26] ? 26'(-prod) : 26'(prod);
      span_mag_r <= span[16] ? 16'(-span) : span[15:0];
      tneg_r     <= prod[26] ^ span[16];
      tfault_r   <= (span == 17'sd0);
    end
    if (cmd.temp_ld) begin
      temp_r <= tfault_r ? 10'd0 : temp_sat;
    end
    if (cmd.ref_ld) begin
      rfault_r <= (avg_r[3] == 16'd0);
      ref_r    <= (avg_r[3] == 16'd0) ? 16'hFFFF : quo_sat;
    end
    if (cmd.out_ld) begin
      out_data_r <= {2'b00, rfault_r, tfault_r, ref_r, temp_r,
                     p_bat_r[27:14], p_in_r[27:16],
                     avg_r[3], avg_r[2], avg_r[1], avg_r[0]};
    end
  end

  assign out_data = out_data_r;

endmodule

>>> src/aca_ctrl.sv
// Controller: sample position, block-end calculation sequence and output handshake.
`timescale 1ns / 1ps
module aca_ctrl #(
  parameter int BLOCK_SAMPLES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  aca_pkg::aca_sts_t sts,
  output aca_pkg::aca_cmd_t cmd
);
  import aca_pkg::*;

  localparam int POS_W = $clog2(BLOCK_SAMPLES);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG,
    ST_MUL,
    ST_TDIV_GO,
    ST_TDIV_WAIT,
    ST_RDIV_GO,
    ST_RDIV_WAIT,
    ST_RESULT
  } state_t;

  state_t           state_r;
  logic [POS_W-1:0] pos_r;
  logic [CH_W-1:0]  ch_r;
  logic             out_valid_r;

  logic last;
  logic accept;

  assign last      = (pos_r == POS_W'(BLOCK_SAMPLES - 1));
  // closing sample of a block waits until the previous block is finished
  assign in_tready = !(last && (state_r != ST_IDLE));
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd           = '0;
    cmd.acc_en    = accept;
    cmd.acc_last  = last;
    cmd.acc_ch    = pos_r[CH_W-1:0];
    cmd.avg_ch    = ch_r;
    cmd.div_op    = DIV_TEMP;
    unique case (state_r)
      ST_IDLE: ;
      ST_AVG:       cmd.avg_ld = 1'b1;
      ST_MUL:       cmd.mul_ld = 1'b1;
      ST_TDIV_GO: begin
        cmd.div_op    = DIV_TEMP;
        cmd.div_start = 1'b1;
      end
      ST_TDIV_WAIT: begin
        cmd.div_op  = DIV_TEMP;
        cmd.temp_ld = sts.div_done;
      end
      ST_RDIV_GO: begin
        cmd.div_op    = DIV_REF;
        cmd.div_start = 1'b1;
      end
      ST_RDIV_WAIT: begin
        cmd.div_op = DIV_REF;
        cmd.ref_ld = sts.div_done;
      end
      ST_RESULT:    cmd.out_ld = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        pos_r <= last ? '0 : pos_r + 1'b1;
      end

      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept && last) begin
            ch_r    <= '0;
            state_r <= ST_AVG;
          end
        end
        ST_AVG: begin
          if (ch_r == CH_W'(NUM_CH - 1)) begin
            state_r <= ST_MUL;
          end else begin
            ch_r <= ch_r + 1'b1;
          end
        end
        ST_MUL:     state_r <= ST_TDIV_GO;
        ST_TDIV_GO: state_r <= ST_TDIV_WAIT;
        ST_TDIV_WAIT: begin
          if (sts.div_done) state_r <= ST_RDIV_GO;
        end
        ST_RDIV_GO: state_r <= ST_RDIV_WAIT;
        ST_RDIV_WAIT: begin
          if (sts.div_done) state_r <= ST_RESULT;
        end
        ST_RESULT: begin
          if (cmd.out_ld) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> src/adc_channel_average_calibrate.sv
// Top level: four-channel ADC oversampling averager with sensor calibration.
`timescale 1ns / 1ps
// Samples arrive on in_* one per cycle while in_tready is high, interleaved over four
// channels by position in the block; after BLOCK_SAMPLES samples one result request leaves
// on out_* carrying the four channel averages (sum / ROUNDS), input and battery voltage in
// mV, the two-point calibrated temperature and the reference voltage with two fault flags.
// The averages come from a reciprocal multiply, one channel per cycle; the temperature and
// reference quotients each run in turn through a single 28-step shift-subtract divider, and
// out_tvalid rises once the result is loaded into the output register, which waits until
// that register is free. Samples keep flowing during the calculation; only the sample that
// closes the next block waits until the previous result has been placed in the output
// register. Configuration is written through cfg_*; the user must write it only while idle,
// as the block itself does not enforce it.
module adc_channel_average_calibrate #(
  parameter int ROUNDS        = 8,
  parameter int BLOCK_SAMPLES = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [aca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aca_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,   // sample_value[15:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // avg_input[15:0], avg_battery[31:16], avg_temp_sensor[47:32], avg_reference[63:48],
  // input_mv[75:64], battery_mv[89:76], temp_c[99:90], reference_mv[115:100],
  // temp_fault[116], reference_fault[117], zero[119:118]
  output logic [aca_pkg::OUT_DATA_W-1:0] out_tdata
);
  import aca_pkg::*;

  localparam int SUM_W = SMP_W + $clog2((BLOCK_SAMPLES + 3) / 4);

  aca_cmd_t cmd;
  aca_sts_t sts;

  aca_ctrl #(
    .BLOCK_SAMPLES (BLOCK_SAMPLES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  aca_dp #(
    .SUM_W  (SUM_W),
    .ROUNDS (ROUNDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .sample    (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_tdata)
  );

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_tvalid || out_tready))
    else $error("pending result overwritten");

  a_temp_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[116]) |-> (out_tdata[99:90] == 10'd0))
    else $error("temp_fault set with nonzero temp_c");

  a_ref_fault_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[117]) |-> (out_tdata[115:100] == 16'hFFFF))
    else $error("reference_fault set without saturated reference_mv");

  a_single_divide: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !cmd.div_start)
    else $error("divider restarted back to back");
`endif

endmodule
